@@ sv/acked_bit_serializer_retry_defines.svh @@
// Assertion helpers shared by the serializer RTL.
`ifndef ACKED_BIT_SERIALIZER_RETRY_DEFINES_SVH
`define ACKED_BIT_SERIALIZER_RETRY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("absr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ABSR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("absr assertion failed");

`endif

@@ sv/absr_pkg.sv @@
`default_nettype none
package absr_pkg;

  // Word geometry
  localparam int DataBits = 8;
  localparam int BitIdxW  = (DataBits > 1) ? $clog2(DataBits) : 1;

  // Field widths
  localparam int KindW    = 2;
  localparam int ByteW    = 8;
  localparam int SigW     = 2;
  localparam int EventW   = 2;
  localparam int STdataW  = 16;  // data_byte + ack_signal, byte padded
  localparam int MTdataW  = 8;   // bit_value, byte padded
  localparam int TimeW    = 20;
  localparam int LimitW   = 4;
  localparam int GapW     = 16;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 20;

  // Input kinds
  localparam logic [KindW-1:0] KindLoad = 2'd0;
  localparam logic [KindW-1:0] KindAck  = 2'd1;
  localparam logic [KindW-1:0] KindTick = 2'd2;

  // Acknowledge signal codes
  localparam logic [SigW-1:0] SigAckA = 2'd1;
  localparam logic [SigW-1:0] SigAckB = 2'd2;

  // Result events
  localparam logic [EventW-1:0] EvSend = 2'd0;
  localparam logic [EventW-1:0] EvDone = 2'd1;
  localparam logic [EventW-1:0] EvErr  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgFirstTimeout = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgRetryTimeout = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgRetryLimit   = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgRetryGap     = 2'd3;

  // Configuration reset values
  localparam logic [TimeW-1:0]  FirstTimeoutRst = 20'd50000;
  localparam logic [TimeW-1:0]  RetryTimeoutRst = 20'd100000;
  localparam logic [LimitW-1:0] RetryLimitRst   = 4'd3;
  localparam logic [GapW-1:0]   RetryGapRst     = 16'd1000;

  // Saturation point of the try counter
  localparam logic [LimitW-1:0] TryMax = '1;

endpackage
`default_nettype wire

@@ sv/acked_bit_serializer_retry.sv @@
// An accepted transaction passes the input register, then the result register that holds
// its result (if any). Throughput: one input transaction per cycle unless the result stream
// stalls; each item updates the counters and flags in one pass between the two registers.
// Reset (rst_ni low, asynchronous): idle, bit index at the top bit, counters clear,
// configuration back to its default values, both channels empty.
`default_nettype none
`include "acked_bit_serializer_retry_defines.svh"
module acked_bit_serializer_retry (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [absr_pkg::STdataW-1:0]    s_axis_tdata,  // [7:0] data_byte, [9:8] ack_signal
  input  wire logic [absr_pkg::KindW-1:0]      s_axis_tuser,  // [1:0] kind
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [absr_pkg::MTdataW-1:0]         m_axis_tdata,  // [0] sent_bit
  output logic [absr_pkg::EventW-1:0]          m_axis_tuser,  // [1:0] event_res
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [absr_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [absr_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import absr_pkg::*;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhWait = 2'd1,
    PhGap  = 2'd2,
    PhFail = 2'd3
  } phase_e;

  // Configuration registers
  logic [TimeW-1:0]  first_timeout_q, retry_timeout_q;
  logic [LimitW-1:0] retry_limit_q;
  logic [GapW-1:0]   retry_gap_q;

  // Input register
  logic              in_valid_q;
  logic [KindW-1:0]  in_kind_q;
  logic [ByteW-1:0]  in_byte_q;
  logic [SigW-1:0]   in_sig_q;

  // Serializer state
  logic [DataBits-1:0] shift_q, shift_d;
  logic [BitIdxW-1:0]  bit_idx_q, bit_idx_d;
  logic [LimitW-1:0]   try_q, try_d;
  logic [TimeW-1:0]    wait_q, wait_d;
  phase_e              phase_q, phase_d;
  logic                ack_q, ack_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [EventW-1:0] out_event_q, out_event_d;
  logic              out_bit_q, out_bit_d;

  logic advance;
  logic take;
  logic is_ack;
  logic go_complete, go_end_gap;
  logic [LimitW-1:0] try_eff;
  logic [BitIdxW-1:0] idx_next;

  // Pipeline control: the input stage drains when the result slot is free
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = in_valid_q && advance;
  assign is_ack        = (in_sig_q == SigAckA) || (in_sig_q == SigAckB);
  assign idx_next      = bit_idx_q - 1'b1;

  // Next-state logic for one item
  always_comb begin
    shift_d     = shift_q;
    bit_idx_d   = bit_idx_q;
    try_d       = try_q;
    wait_d      = wait_q;
    phase_d     = phase_q;
    ack_d       = ack_q;
    out_valid_d = 1'b0;
    out_event_d = EvSend;
    out_bit_d   = 1'b0;
    go_complete = 1'b0;
    go_end_gap  = 1'b0;
    try_eff     = try_q;

    if (take) begin
      case (in_kind_q)
        KindLoad: begin
          if (phase_q == PhIdle) begin
            shift_d     = DataBits'(in_byte_q);
            bit_idx_d   = BitIdxW'(DataBits - 1);
            try_d       = '0;
            ack_d       = 1'b0;
            wait_d      = first_timeout_q;
            phase_d     = PhWait;
            out_valid_d = 1'b1;
            out_event_d = EvSend;
            out_bit_d   = in_byte_q[DataBits-1];
          end
        end
        KindAck: begin
          if (is_ack) begin
            if (phase_q == PhWait) begin
              go_complete = 1'b1;
            end else if (phase_q == PhGap) begin
              ack_d = 1'b1;
            end
          end
        end
        KindTick: begin
          if (phase_q == PhWait) begin
            if (ack_q) begin
              go_complete = 1'b1;
            end else if (wait_q > TimeW'(1)) begin
              wait_d = wait_q - 1'b1;
            end else begin
              try_eff = (try_q != TryMax) ? try_q + 1'b1 : try_q;
              try_d   = try_eff;
              phase_d = PhGap;
              wait_d  = TimeW'(retry_gap_q);
              go_end_gap = (retry_gap_q == '0);
            end
          end else if (phase_q == PhGap) begin
            if (wait_q > TimeW'(1)) begin
              wait_d = wait_q - 1'b1;
            end else begin
              go_end_gap = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      // Bit acknowledged: move to the next bit or finish the word
      if (go_complete) begin
        ack_d       = 1'b0;
        try_d       = '0;
        out_valid_d = 1'b1;
        if (bit_idx_q == '0) begin
          phase_d     = PhIdle;
          wait_d      = '0;
          out_event_d = EvDone;
        end else begin
          bit_idx_d   = idx_next;
          wait_d      = first_timeout_q;
          phase_d     = PhWait;
          out_event_d = EvSend;
          out_bit_d   = shift_q[idx_next];
        end
      end

      // Gap over: resend or give up
      if (go_end_gap) begin
        out_valid_d = 1'b1;
        if (try_eff >= retry_limit_q) begin
          phase_d     = PhFail;
          ack_d       = 1'b0;
          wait_d      = '0;
          out_event_d = EvErr;
        end else begin
          wait_d      = retry_timeout_q;
          phase_d     = PhWait;
          out_event_d = EvSend;
          out_bit_d   = shift_q[bit_idx_q];
        end
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_timeout_q <= FirstTimeoutRst;
      retry_timeout_q <= RetryTimeoutRst;
      retry_limit_q   <= RetryLimitRst;
      retry_gap_q     <= RetryGapRst;
      in_valid_q      <= 1'b0;
      shift_q         <= '0;
      bit_idx_q       <= BitIdxW'(DataBits - 1);
      try_q           <= '0;
      wait_q          <= '0;
      phase_q         <= PhIdle;
      ack_q           <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgFirstTimeout: first_timeout_q <= cfg_wdata_i[TimeW-1:0];
          CfgRetryTimeout: retry_timeout_q <= cfg_wdata_i[TimeW-1:0];
          CfgRetryLimit:   retry_limit_q   <= cfg_wdata_i[LimitW-1:0];
          CfgRetryGap:     retry_gap_q     <= cfg_wdata_i[GapW-1:0];
          default: begin
          end
        endcase
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      shift_q   <= shift_d;
      bit_idx_q <= bit_idx_d;
      try_q     <= try_d;
      wait_q    <= wait_d;
      phase_q   <= phase_d;
      ack_q     <= ack_d;
      if (advance) begin
        out_valid_q <= out_valid_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[ByteW-1:0];
      in_sig_q  <= s_axis_tdata[ByteW+SigW-1:ByteW];
    end
    if (advance) begin
      out_event_q <= out_event_d;
      out_bit_q   <= out_bit_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_event_q;
  assign m_axis_tdata  = {(MTdataW-1)'(0), out_bit_q};

  // Checks
  `ABSR_ASSERT_NXT(a_fail_sticks, clk_i, rst_ni, phase_q == PhFail, phase_q == PhFail)
  `ABSR_ASSERT_IMP(a_err_in_fail, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == EvErr), phase_q == PhFail)
  `ABSR_ASSERT_IMP(a_ready_when_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule
`default_nettype wire
